@@ rtl/conv_wc_pkg.sv @@
package conv_wc_pkg;

  localparam int unsigned DEF_STORE_DEPTH  = 16384;
  localparam int unsigned DEF_MAX_CHANNELS = 1024;
  localparam int unsigned DEF_WEIGHT_BITS  = 16;

  localparam int LANE_BITS   = 16;
  localparam int LANES       = 9;
  localparam int CENTRE_LANE = 4;
  localparam int LANE_IDX_W  = 4;
  localparam int CHAN_W      = 10;
  localparam int CHAN_CFG_W  = 11;
  // output channel count scaled by nine still fits here
  localparam int CHAN9_W     = 15;
  localparam int PROD_W      = CHAN_W + CHAN9_W;
  localparam int SUM_W       = PROD_W + 1;
  localparam int CFG_DATA_W  = 11;
  localparam int CFG_IDX_W   = 1;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    REQ_BEGIN  = 2'd0,
    REQ_LOAD   = 2'd1,
    REQ_FETCH9 = 2'd2,
    REQ_FETCH1 = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KERNEL   = 1'b0,
    CFG_CHANNELS = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    CMD_BEGIN = 3'd0,
    CMD_LOAD  = 3'd1,
    CMD_READ1 = 3'd2,
    CMD_READ9 = 3'd3,
    CMD_FAULT = 3'd4
  } cmd_e;

  typedef logic signed [LANE_BITS-1:0] lane_t;

  typedef struct packed {
    cmd_e               cmd;
    lane_t              weight;
    logic [SUM_W-1:0]   sum;
  } cmd_t;

  typedef struct packed {
    logic                  kernel_3x3;
    logic [CHAN_CFG_W-1:0] channels;
  } cfg_t;

endpackage

@@ rtl/conv_weight_cache_unit.sv @@
// channel  dir  handshake                 payload
// in       in   in_valid_i / in_stall_o   req_type_i weight_value_i in_channel_i out_channel_i
// out      out  out_valid_o / out_stall_i lane_0_o .. lane_8_o status_o
// cfg      in   cfg_we_i                  cfg_addr_i cfg_wdata_i
//
// the front takes one request per cycle while in_stall_o is low into a two-stage address
// pipeline (multiply, then add and range check) feeding a two-entry queue
// the back runs one request at a time off the single store read port: begin, load and
// range faults answer straight from idle, fetches pass through the read and drain states
// reset clears the fill pointer and all valid state and sets the config registers to 1x1
// kernel and one channel; the weight store itself is not cleared
// a stalled result sits in the output register while the front keeps filling the queue
module conv_weight_cache_unit import conv_wc_pkg::*; #(
  parameter int unsigned STORE_DEPTH  = DEF_STORE_DEPTH,
  parameter int unsigned MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter int unsigned WEIGHT_BITS  = DEF_WEIGHT_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]       cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  req_type_i,
  input  logic signed [LANE_BITS-1:0] weight_value_i,
  input  logic [CHAN_W-1:0]           in_channel_i,
  input  logic [CHAN_W-1:0]           out_channel_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [LANE_BITS-1:0] lane_0_o,
  output logic signed [LANE_BITS-1:0] lane_1_o,
  output logic signed [LANE_BITS-1:0] lane_2_o,
  output logic signed [LANE_BITS-1:0] lane_3_o,
  output logic signed [LANE_BITS-1:0] lane_4_o,
  output logic signed [LANE_BITS-1:0] lane_5_o,
  output logic signed [LANE_BITS-1:0] lane_6_o,
  output logic signed [LANE_BITS-1:0] lane_7_o,
  output logic signed [LANE_BITS-1:0] lane_8_o,
  output logic [1:0]                  status_o
);

  cfg_t    cfg_q;
  logic    q_push, q_full, q_pop, q_empty;
  cmd_t    q_wdata, q_rdata;
  lane_t   lanes [LANES];
  status_e status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kernel_3x3 <= 1'b0;
      cfg_q.channels   <= CHAN_CFG_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_KERNEL:   cfg_q.kernel_3x3 <= cfg_wdata_i[0];
        CFG_CHANNELS: cfg_q.channels   <= cfg_wdata_i;
        default:      cfg_q            <= cfg_q;
      endcase
    end
  end

  conv_wc_front #(
    .STORE_DEPTH  (STORE_DEPTH),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .weight_value_i (weight_value_i),
    .in_channel_i   (in_channel_i),
    .out_channel_i  (out_channel_i),
    .push_o         (q_push),
    .push_data_o    (q_wdata),
    .full_i         (q_full)
  );

  conv_wc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_data_o  (q_rdata)
  );

  conv_wc_back #(
    .STORE_DEPTH (STORE_DEPTH),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (!q_empty),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .lanes_o     (lanes),
    .status_o    (status)
  );

  assign lane_0_o = lanes[0];
  assign lane_1_o = lanes[1];
  assign lane_2_o = lanes[2];
  assign lane_3_o = lanes[3];
  assign lane_4_o = lanes[4];
  assign lane_5_o = lanes[5];
  assign lane_6_o = lanes[6];
  assign lane_7_o = lanes[7];
  assign lane_8_o = lanes[8];
  assign status_o = status;

  a_queue_no_overflow: assert property (
    @(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_full
  ) else $error("request queue written while full");

  a_queue_no_underflow: assert property (
    @(posedge clk_i) disable iff (!rst_ni) q_pop |-> !q_empty
  ) else $error("request queue read while empty");

  a_fault_lanes_zero: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != STATUS_OK) |->
      (lane_0_o == '0 && lane_1_o == '0 && lane_2_o == '0 &&
       lane_3_o == '0 && lane_4_o == '0 && lane_5_o == '0 &&
       lane_6_o == '0 && lane_7_o == '0 && lane_8_o == '0)
  ) else $error("refused or out of range request carries nonzero lanes");

endmodule

@@ rtl/conv_wc_front.sv @@
module conv_wc_front import conv_wc_pkg::*; #(
  parameter int unsigned STORE_DEPTH  = DEF_STORE_DEPTH,
  parameter int unsigned MAX_CHANNELS = DEF_MAX_CHANNELS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        req_type_i,
  input  lane_t             weight_value_i,
  input  logic [CHAN_W-1:0] in_channel_i,
  input  logic [CHAN_W-1:0] out_channel_i,
  output logic              push_o,
  output cmd_t              push_data_o,
  input  logic              full_i
);

  localparam logic [SUM_W-1:0] ROW_LIMIT  = SUM_W'(STORE_DEPTH / LANES);
  localparam logic [SUM_W-1:0] ADDR_LIMIT = SUM_W'(STORE_DEPTH);

  logic              s1_v_q, s2_v_q;
  req_e              s1_req_q, s2_req_q;
  lane_t             s1_weight_q, s2_weight_q;
  logic [CHAN_W-1:0] s1_ci_q, s1_co_q, s2_co_q;
  logic [PROD_W-1:0] s2_prod_q, prod_d;
  logic              s2_chan_ok_q, chan_ok_d;

  logic               s1_free, s2_free, in_acc, s1_move;
  logic [CHAN9_W-1:0] chan9, chan_eff;
  logic [SUM_W-1:0]   sum;
  cmd_e               cmd;

  assign push_o     = s2_v_q && !full_i;
  assign s2_free    = !s2_v_q || push_o;
  assign s1_free    = !s1_v_q || s2_free;
  assign in_stall_o = !s1_free;
  assign in_acc     = in_valid_i && s1_free;
  assign s1_move    = s1_v_q && s2_free;

  // x9 as x8 + x
  assign chan9 = CHAN9_W'({cfg_i.channels, 3'b000}) + CHAN9_W'(cfg_i.channels);
  // fetch one in 3x3 mode strides input channels by nine weights per filter
  assign chan_eff = (s1_req_q == REQ_FETCH1 && cfg_i.kernel_3x3) ? chan9
                                                                 : CHAN9_W'(cfg_i.channels);
  assign prod_d    = PROD_W'(s1_ci_q) * PROD_W'(chan_eff);
  assign chan_ok_d = (32'(s1_ci_q) < 32'(MAX_CHANNELS)) &&
                     (32'(s1_co_q) < 32'(MAX_CHANNELS));

  assign sum = SUM_W'(s2_prod_q) + SUM_W'(s2_co_q);

  always_comb begin
    unique case (s2_req_q)
      REQ_BEGIN: cmd = CMD_BEGIN;
      REQ_LOAD:  cmd = CMD_LOAD;
      REQ_FETCH9: begin
        // in 3x3 mode sum is the filter index, the base address is nine times it
        if (cfg_i.kernel_3x3) begin
          cmd = (!s2_chan_ok_q || sum >= ROW_LIMIT) ? CMD_FAULT : CMD_READ9;
        end else begin
          cmd = (!s2_chan_ok_q || sum >= ADDR_LIMIT) ? CMD_FAULT : CMD_READ1;
        end
      end
      REQ_FETCH1: cmd = (!s2_chan_ok_q || sum >= ADDR_LIMIT) ? CMD_FAULT : CMD_READ1;
      default:    cmd = CMD_FAULT;
    endcase
  end

  assign push_data_o.cmd    = cmd;
  assign push_data_o.weight = s2_weight_q;
  assign push_data_o.sum    = sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_v_q <= in_valid_i;
      end
      if (s2_free) begin
        s2_v_q <= s1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_req_q    <= req_e'(req_type_i);
      s1_weight_q <= weight_value_i;
      s1_ci_q     <= in_channel_i;
      s1_co_q     <= out_channel_i;
    end
    if (s1_move) begin
      s2_req_q     <= s1_req_q;
      s2_weight_q  <= s1_weight_q;
      s2_co_q      <= s1_co_q;
      s2_prod_q    <= prod_d;
      s2_chan_ok_q <= chan_ok_d;
    end
  end

endmodule

@@ rtl/conv_wc_queue.sv @@
module conv_wc_queue import conv_wc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t pop_data_o
);

  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          entries_q [QUEUE_DEPTH];
  logic [QW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;

  function automatic logic [QW-1:0] next_ptr(input logic [QW-1:0] p);
    return (p == QW'(QUEUE_DEPTH - 1)) ? '0 : QW'(p + 1'b1);
  endfunction

  assign full_o     = (count_q == CW'(QUEUE_DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ rtl/conv_wc_back.sv @@
module conv_wc_back import conv_wc_pkg::*; #(
  parameter int unsigned STORE_DEPTH = DEF_STORE_DEPTH,
  parameter int unsigned WEIGHT_BITS = DEF_WEIGHT_BITS
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    q_valid_i,
  input  cmd_t    q_data_i,
  output logic    q_pop_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output lane_t   lanes_o [LANES],
  output status_e status_o
);

  localparam int AW    = $clog2(STORE_DEPTH);
  localparam int PW    = AW + 1;
  localparam int EXT_W = (WEIGHT_BITS > LANE_BITS) ? WEIGHT_BITS : LANE_BITS;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_READ  = 3'b010,
    ST_DRAIN = 3'b100
  } bk_state_e;

  logic [WEIGHT_BITS-1:0] store_mem [STORE_DEPTH];
  logic [WEIGHT_BITS-1:0] rd_data_q;

  bk_state_e             state_q;
  logic [PW-1:0]         fill_ptr_q;
  logic [AW-1:0]         rd_addr_q;
  logic [LANE_IDX_W-1:0] issue_lane_q, cap_lane_q;
  logic                  single_q, cap_v_q, cap_last_q;
  logic                  out_valid_q;
  lane_t                 lanes_q [LANES];
  status_e               status_q;

  logic          out_free, store_full, mem_we, issue_done;
  logic          res_set, out_valid_d;
  logic [AW-1:0] row, addr9;

  function automatic lane_t to_lane(input logic [WEIGHT_BITS-1:0] w);
    logic [EXT_W-1:0] wide;
    wide = EXT_W'($signed(w));
    return wide[LANE_BITS-1:0];
  endfunction

  assign out_free   = !out_valid_q || !out_stall_i;
  assign q_pop_o    = (state_q == ST_IDLE) && q_valid_i && out_free;
  assign store_full = (fill_ptr_q >= PW'(STORE_DEPTH));
  assign mem_we     = q_pop_o && (q_data_i.cmd == CMD_LOAD) && !store_full;
  assign issue_done = single_q || (issue_lane_q == LANE_IDX_W'(LANES - 1));

  // begin, load and faults answer at once, reads once their last lane lands
  assign res_set     = (q_pop_o && q_data_i.cmd != CMD_READ1 && q_data_i.cmd != CMD_READ9) ||
                       (cap_v_q && cap_last_q);
  assign out_valid_d = (out_valid_q && out_stall_i) || res_set;

  // base address of a 3x3 filter: row * 9 as row * 8 + row
  assign row   = q_data_i.sum[AW-1:0];
  assign addr9 = AW'({row, 3'b000}) + row;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[fill_ptr_q[AW-1:0]] <= WEIGHT_BITS'($unsigned(q_data_i.weight));
    end
    if (state_q == ST_READ) begin
      rd_data_q <= store_mem[rd_addr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      fill_ptr_q   <= '0;
      rd_addr_q    <= '0;
      issue_lane_q <= '0;
      cap_lane_q   <= '0;
      single_q     <= 1'b0;
      cap_v_q      <= 1'b0;
      cap_last_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      status_q     <= STATUS_OK;
      for (int i = 0; i < LANES; i++) begin
        lanes_q[i] <= '0;
      end
    end else begin
      cap_v_q     <= (state_q == ST_READ);
      out_valid_q <= out_valid_d;

      unique case (state_q)
        ST_IDLE: begin
          if (q_pop_o) begin
            for (int i = 0; i < LANES; i++) begin
              lanes_q[i] <= '0;
            end
            unique case (q_data_i.cmd)
              CMD_BEGIN: begin
                fill_ptr_q <= '0;
                status_q   <= STATUS_OK;
              end
              CMD_LOAD: begin
                if (store_full) begin
                  status_q <= STATUS_FULL;
                end else begin
                  fill_ptr_q <= fill_ptr_q + 1'b1;
                  status_q   <= STATUS_OK;
                end
              end
              CMD_READ1: begin
                rd_addr_q    <= row;
                issue_lane_q <= LANE_IDX_W'(CENTRE_LANE);
                single_q     <= 1'b1;
                status_q     <= STATUS_OK;
                state_q      <= ST_READ;
              end
              CMD_READ9: begin
                rd_addr_q    <= addr9;
                issue_lane_q <= '0;
                single_q     <= 1'b0;
                status_q     <= STATUS_OK;
                state_q      <= ST_READ;
              end
              default: begin
                status_q <= STATUS_RANGE;
              end
            endcase
          end
        end
        ST_READ: begin
          // one store read per cycle, captured into its lane in the cycle after
          cap_lane_q   <= issue_lane_q;
          cap_last_q   <= issue_done;
          rd_addr_q    <= rd_addr_q + 1'b1;
          issue_lane_q <= issue_lane_q + 1'b1;
          if (issue_done) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
        end
        default: state_q <= ST_IDLE;
      endcase

      if (cap_v_q) begin
        lanes_q[cap_lane_q] <= to_lane(rd_data_q);
        if (cap_last_q) begin
          state_q <= ST_IDLE;
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign lanes_o     = lanes_q;
  assign status_o    = status_q;

endmodule
